### rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES package
// Shared constants, types and round functions for the AES-128 CBC core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned BlockW  = 128;
  localparam int unsigned HalfW   = 64;
  localparam int unsigned Rounds  = 10;
  localparam int unsigned RoundW  = 4;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_IV_HIGH  = 2'd2,
    REG_IV_LOW   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic          start;
    logic          last;
    logic [RoundW-1:0] round;
  } round_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] tbl [256];
    tbl = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return tbl[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input logic [BlockW-1:0] b, input int i);
    return b[BlockW-1-8*i -: 8];
  endfunction

  function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### rtl/aes_key_step.sv
// ----------------------------------------------------------------------------
// AES key schedule step
// Holds the current round key and derives the next one each round.
// ----------------------------------------------------------------------------
module aes_key_step (
  input  logic                          clk_i,
  input  aes_pkg::round_ctl_t           ctl_i,
  input  logic                          adv_i,
  input  logic [aes_pkg::BlockW-1:0]    key_i,
  output logic [aes_pkg::BlockW-1:0]    rk_next_o
);

  logic [aes_pkg::BlockW-1:0] rk_q, rk_d;
  logic [31:0] t;
  logic [31:0] w [4];

  always_comb begin
    t = {aes_pkg::sbox(rk_q[23:16]) ^ aes_pkg::rcon(ctl_i.round),
         aes_pkg::sbox(rk_q[15:8]), aes_pkg::sbox(rk_q[7:0]),
         aes_pkg::sbox(rk_q[31:24])};
    w[0] = rk_q[127:96] ^ t;
    w[1] = rk_q[95:64] ^ w[0];
    w[2] = rk_q[63:32] ^ w[1];
    w[3] = rk_q[31:0] ^ w[2];
    rk_next_o = {w[0], w[1], w[2], w[3]};
  end

  always_comb begin
    rk_d = rk_q;
    if (ctl_i.start) begin
      rk_d = key_i;
    end else if (adv_i) begin
      rk_d = rk_next_o;
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q <= rk_d;
  end

endmodule

### rtl/aes_round.sv
// ----------------------------------------------------------------------------
// AES round unit
// One shared round: SubBytes, ShiftRows, MixColumns (skipped on last), AddRoundKey.
// ----------------------------------------------------------------------------
module aes_round (
  input  aes_pkg::round_ctl_t          ctl_i,
  input  logic [aes_pkg::BlockW-1:0]   state_i,
  input  logic [aes_pkg::BlockW-1:0]   rk_i,
  output logic [aes_pkg::BlockW-1:0]   state_o
);

  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] a0, a1, a2, a3, all;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = aes_pkg::sbox(aes_pkg::get_byte(state_i, r + 4*((c + r) & 3)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (ctl_i.last) begin
        m[4*c] = a0; m[4*c+1] = a1; m[4*c+2] = a2; m[4*c+3] = a3;
      end else begin
        m[4*c]   = a0 ^ all ^ aes_pkg::xtime(a0 ^ a1);
        m[4*c+1] = a1 ^ all ^ aes_pkg::xtime(a1 ^ a2);
        m[4*c+2] = a2 ^ all ^ aes_pkg::xtime(a2 ^ a3);
        m[4*c+3] = a3 ^ all ^ aes_pkg::xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      state_o[aes_pkg::BlockW-1-8*i -: 8] = m[i] ^ aes_pkg::get_byte(rk_i, i);
    end
  end

endmodule

### rtl/aes128_cbc_encrypt_core.sv
// ----------------------------------------------------------------------------
// AES-128 CBC encryption core
// Encrypts one 128-bit block per transfer, chaining from the IV or the
// previous ciphertext.
// ----------------------------------------------------------------------------
// Each input transfer loads the key and the whitened, chained block; the core
// then runs the ten AES rounds, one per cycle, through a single shared round
// unit with an on-the-fly key schedule. It takes no new block until the
// ciphertext is in the output register. If the previous result is still
// waiting in the output register when a block finishes, the core holds the
// finished block and stays busy until the output register frees. Byte 0 of
// key, IV and data is the top byte of the high half.
module aes128_cbc_encrypt_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [aes_pkg::CfgAddrW-1:0]  paddr,
  input  logic [aes_pkg::CfgDataW-1:0]  pwdata,
  output logic [aes_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [127:0]                  s_axis_tdata,  // plain_low, plain_high
  input  logic                          s_axis_tuser,  // first_block
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [127:0]                  m_axis_tdata   // cipher_low, cipher_high
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic [63:0] chain_high_q, chain_low_q;
  logic [127:0] blk_q, blk_d, rk_next, round_out, plain;
  logic [127:0] out_q;
  logic out_valid_q, out_free, out_load;
  logic [aes_pkg::RoundW-1:0] round_q, round_d;
  aes_pkg::round_ctl_t ctl;
  logic in_fire, wr;
  logic [1:0] widx;

  assign pready = 1'b1;
  assign wr   = psel & penable & pwrite;
  assign widx = paddr[4:3];

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      case (aes_pkg::reg_idx_e'(widx))
        aes_pkg::REG_KEY_HIGH: prdata = key_high_q;
        aes_pkg::REG_KEY_LOW:  prdata = key_low_q;
        aes_pkg::REG_IV_HIGH:  prdata = iv_high_q;
        aes_pkg::REG_IV_LOW:   prdata = iv_low_q;
        default:               prdata = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      iv_high_q  <= '0;
      iv_low_q   <= '0;
    end else if (wr && paddr[2:0] == 3'd0) begin
      case (aes_pkg::reg_idx_e'(widx))
        aes_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
        aes_pkg::REG_KEY_LOW:  key_low_q  <= pwdata;
        aes_pkg::REG_IV_HIGH:  iv_high_q  <= pwdata;
        aes_pkg::REG_IV_LOW:   iv_low_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // plain_high travels in the low half of tdata.
  assign plain = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

  assign s_axis_tready = state_q[0];
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q[63:0], out_q[127:64]};

  // The output register can take a new result when empty or emptying now.
  assign out_free = ~out_valid_q | m_axis_tready;
  assign out_load = ((state_q[1] & ctl.last) | state_q[2]) & out_free;

  assign ctl.start = in_fire;
  assign ctl.round = round_q;
  assign ctl.last  = (round_q == aes_pkg::RoundW'(aes_pkg::Rounds));

  aes_key_step u_key (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .adv_i     (state_q[1]),
    .key_i     ({key_high_q, key_low_q}),
    .rk_next_o (rk_next)
  );

  aes_round u_round (
    .ctl_i   (ctl),
    .state_i (blk_q),
    .rk_i    (rk_next),
    .state_o (round_out)
  );

  always_comb begin
    state_d = state_q;
    round_d = round_q;
    blk_d   = blk_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          // Initial AddRoundKey folded into the load.
          blk_d = plain ^ {key_high_q, key_low_q} ^
                  (s_axis_tuser ? {iv_high_q, iv_low_q} : {chain_high_q, chain_low_q});
          round_d = aes_pkg::RoundW'(1);
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        blk_d   = round_out;
        round_d = round_q + aes_pkg::RoundW'(1);
        if (ctl.last) begin
          state_d = out_free ? ST_IDLE : ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      round_q      <= '0;
      chain_high_q <= '0;
      chain_low_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      round_q <= round_d;
      if (state_q[1] && ctl.last) begin
        {chain_high_q, chain_low_q} <= round_out;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    if (out_load) begin
      out_q <= state_q[2] ? blk_q : round_out;
    end
  end

endmodule
